/* hdl/tflm_pkg.sv */
package tflm_pkg;

  // field widths of the words on the channels
  localparam int TimeW  = 53;
  localparam int PriceW = 31;
  localparam int QtyW   = 31;
  localparam int SideW  = 2;
  localparam int StatW  = 3;
  localparam int IdxOutW = 12;
  localparam int DelayCfgW = 32;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam logic [DelayCfgW-1:0] MAX_DELAY_RESET = 32'd3000000;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_MATCH  = 1'b1
  } opcode_t;

  typedef enum logic [StatW-1:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_MATCHED = 3'd2,
    ST_GAVE_UP = 3'd3,
    ST_END     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FETCH,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic [TimeW-1:0]  time_us;
    logic [PriceW-1:0] price_cents;
    logic [QtyW-1:0]   quantity;
    logic [SideW-1:0]  side;
  } in_word_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [TimeW-1:0]   delay_us;
    logic [IdxOutW-1:0] entry_index;
  } out_word_t;

  typedef logic [DelayCfgW-1:0] cfg_word_t;

  // one stored exchange trade event
  typedef struct packed {
    logic [TimeW-1:0]  time_us;
    logic [PriceW-1:0] price_cents;
    logic [QtyW-1:0]   qty;
    logic [SideW-1:0]  side;
  } entry_t;

  // verdict of the compare unit on one table entry
  typedef struct packed {
    logic             skip;
    logic             give_up;
    logic             hit;
    logic [TimeW-1:0] delay;
    logic [QtyW-1:0]  new_qty;
  } verdict_t;

endpackage

/* hdl/tflm_chan_if.sv */
interface tflm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/tflm_ram.sv */
module tflm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hdl/tflm_cmp_unit.sv */
module tflm_cmp_unit (
  input  tflm_pkg::entry_t    entry,
  input  tflm_pkg::in_word_t  item,
  input  tflm_pkg::cfg_word_t max_delay,
  input  logic                missed,
  output tflm_pkg::verdict_t  verdict
);
  import tflm_pkg::*;

  logic [TimeW-1:0] diff;
  logic             too_late;

  assign diff     = entry.time_us - item.time_us;
  assign too_late = diff > TimeW'(max_delay);

  always_comb begin
    verdict.skip    = item.time_us > entry.time_us;
    verdict.give_up = !verdict.skip && missed && too_late;
    verdict.hit     = !verdict.skip && !verdict.give_up
                      && (entry.price_cents == item.price_cents)
                      && (entry.qty >= item.quantity)
                      && (entry.side != item.side);
    verdict.delay   = diff;
    verdict.new_qty = entry.qty - item.quantity;
  end
endmodule

/* hdl/trade_to_feed_latency_matcher.sv */
// trade-to-feed latency matcher: keeps a table of exchange trade events in one
// block ram and matches own trades against it. an append word (opcode 0) is
// written to the table in S_APPEND unless the table is full, and its result
// then goes through S_DONE into the output register. a match word (opcode 1)
// reads the entry at the search cursor in S_FETCH and walks on in S_EVAL, where
// a single compare unit checks one entry per cycle behind the ram's registered
// read port. input ready is low while a word is in work. the result waits in
// an output register, and input ready rises in the cycle after the result is
// loaded there. a stalled result holds the block until the output register is
// free. table storage is not cleared after reset: only entries below the event
// count are read. the user must write max_delay_us over the cfg channel only
// while the block is idle; the block itself does not enforce this.
module trade_to_feed_latency_matcher #(
  parameter int TABLE_DEPTH = tflm_pkg::TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tflm_chan_if.sink   in_chan,
  tflm_chan_if.source out_chan,
  tflm_chan_if.sink   cfg
);
  import tflm_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = $bits(entry_t);

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count;        // events stored
  logic [CNT_W-1:0] cursor;       // where the next scan starts
  logic [CNT_W-1:0] first_miss;   // rewind point of the current scan
  logic             missed;
  cfg_word_t        max_delay;

  // payload
  in_word_t         item;
  out_word_t        res;

  // ram side
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  verdict_t         verdict;
  logic             in_accept, out_load, out_free;
  logic [CNT_W-1:0] cur_inc;
  logic             at_end, last, cont, full;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign out_free  = !out_chan.valid || out_chan.ready;
  assign cur_inc   = cursor + 1'b1;
  assign at_end    = cursor >= count;
  assign last      = cur_inc >= count;
  assign cont      = !verdict.give_up && !verdict.hit;
  assign full      = count == CNT_W'(TABLE_DEPTH);
  assign cfg.ready = 1'b1;

  tflm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the one compare/subtract unit, reused for every entry visited
  tflm_cmp_unit u_cmp (
    .entry     (ram_rdata),
    .item      (item),
    .max_delay (max_delay),
    .missed    (missed),
    .verdict   (verdict)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (in_chan.data.opcode == OP_APPEND) ? S_APPEND : S_FETCH;
        end
      end
      S_APPEND: state_next = S_DONE;
      S_FETCH:  state_next = at_end ? S_DONE : S_EVAL;
      S_EVAL: begin
        if (!cont || last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cursor[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = cursor[IDX_W-1:0];
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: in_chan.ready = 1'b1;
      S_APPEND: begin
        // new event goes at the end of the table
        ram_we                = !full;
        ram_waddr             = count[IDX_W-1:0];
        ram_wdata.time_us     = item.time_us;
        ram_wdata.price_cents = item.price_cents;
        ram_wdata.qty         = item.quantity;
        ram_wdata.side        = item.side;
      end
      S_FETCH: ram_re = !at_end;
      S_EVAL: begin
        // fetch the following entry while this one is judged
        ram_re        = cont && !last;
        ram_raddr     = cur_inc[IDX_W-1:0];
        // on a hit write back the entry with its quantity reduced
        ram_we        = verdict.hit;
        ram_wdata.qty = verdict.new_qty;
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      missed    <= 1'b0;
      max_delay <= MAX_DELAY_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        max_delay <= cfg.data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            item   <= in_chan.data;
            missed <= 1'b0;
          end
        end
        S_APPEND: begin
          res.delay_us <= '0;
          if (full) begin
            res.status      <= ST_FULL;
            res.entry_index <= '0;
          end else begin
            res.status      <= ST_LOADED;
            res.entry_index <= IdxOutW'(count);
            count           <= count + 1'b1;
          end
        end
        S_FETCH: begin
          if (at_end) begin
            cursor          <= count;
            res.status      <= ST_END;
            res.delay_us    <= '0;
            res.entry_index <= '0;
          end
        end
        S_EVAL: begin
          if (verdict.give_up) begin
            // window exceeded after a miss: rewind to the first miss
            cursor          <= first_miss;
            res.status      <= ST_GAVE_UP;
            res.delay_us    <= '0;
            res.entry_index <= '0;
          end else if (verdict.hit) begin
            // cursor stays on the matched entry
            res.status      <= ST_MATCHED;
            res.delay_us    <= verdict.delay;
            res.entry_index <= IdxOutW'(cursor);
          end else begin
            if (!verdict.skip && !missed) begin
              missed     <= 1'b1;
              first_miss <= cursor;
            end
            if (last) begin
              cursor          <= count;
              res.status      <= ST_END;
              res.delay_us    <= '0;
              res.entry_index <= '0;
            end else begin
              cursor <= cur_inc;
            end
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // output register parts the result from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (out_load) begin
      out_chan.valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan.data <= res;
    end
  end

  // the cursor never runs past the stored events
  a_cursor_in_table: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("search cursor beyond event count");

  // the table never holds more than its depth
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("event count beyond table depth");

  // the event count only ever grows by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> count == $past(count) + 1'b1)
    else $error("event count jumped");

  // a word in work blocks the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_chan.ready)
    else $error("input taken while a word is in work");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

// checks the trade-to-feed latency matcher against a predictor of its own:
// a short table of directed words first, then random phases under a range of
// max_delay_us settings

module tb;
  import tflm_pkg::*;

  localparam int TableDepth = TABLE_DEPTH_DEF;

  localparam logic [TimeW-1:0]  TimeMax  = '1;
  localparam logic [PriceW-1:0] PriceMax = '1;
  localparam logic [QtyW-1:0]   QtyMax   = '1;

  // aggressor side codes as the feed carries them
  localparam logic [SideW-1:0] SideBuy  = 2'd0;
  localparam logic [SideW-1:0] SideSell = 2'd1;
  localparam logic [SideW-1:0] SideNone = 2'd2;
  localparam logic [SideW-1:0] SideOdd  = 2'd3;

  // one line of the directed table; want is only used where typed is set
  typedef struct packed {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  tflm_chan_if #(.T(in_word_t))  in_chan ();
  tflm_chan_if #(.T(out_word_t)) out_chan ();
  tflm_chan_if #(.T(cfg_word_t)) cfg ();

  trade_to_feed_latency_matcher #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg      (cfg)
  );

  // predictor state: our own copy of the event table, count, cursor and window
  entry_t           feed_tab [TableDepth];
  int unsigned      feed_count = 0;
  int unsigned      scan_pos = 0;
  cfg_word_t        window_us = MAX_DELAY_RESET;

  // expected result words, oldest first
  out_word_t        outcome_q [$];
  int unsigned      err_count = 0;

  // stimulus shaping
  bit               in_gaps = 1'b1;
  bit               out_stalls = 1'b1;
  logic [TimeW-1:0] feed_time;
  logic [PriceW-1:0] base_price;

  stim_row_t        directed_rows [19];
  cfg_word_t        cfg_plan [5];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // predicted outcome of one word; updates the predictor state as the block would
  function automatic out_word_t feed_outcome(in_word_t w);
    out_word_t   r;
    entry_t      e;
    bit          missed;
    int unsigned first_miss;
    r = '0;
    if (w.opcode == OP_APPEND) begin
      // table full: nothing stored
      if (feed_count >= TableDepth) begin
        r.status = ST_FULL;
        return r;
      end
      feed_tab[feed_count] = '{time_us: w.time_us, price_cents: w.price_cents,
                               qty: w.quantity, side: w.side};
      r.status      = ST_LOADED;
      r.entry_index = IdxOutW'(feed_count);
      feed_count++;
      return r;
    end
    missed     = 1'b0;
    first_miss = 0;
    if (scan_pos > feed_count) scan_pos = feed_count;
    while (scan_pos < feed_count && scan_pos < TableDepth) begin
      e = feed_tab[scan_pos];
      // events older than the trade are stepped over
      if (w.time_us <= e.time_us) begin
        // an earlier miss and a gap beyond the window: give up, rewind
        if (missed && (e.time_us - w.time_us) > TimeW'(window_us)) begin
          scan_pos = first_miss;
          r.status = ST_GAVE_UP;
          return r;
        end
        if (e.price_cents == w.price_cents && e.qty >= w.quantity &&
            e.side != w.side) begin
          // cursor stays on the hit so the rest of its quantity can go later
          feed_tab[scan_pos].qty = e.qty - w.quantity;
          r.status      = ST_MATCHED;
          r.delay_us    = e.time_us - w.time_us;
          r.entry_index = IdxOutW'(scan_pos);
          return r;
        end
        if (!missed) begin
          missed     = 1'b1;
          first_miss = scan_pos;
        end
      end
      scan_pos++;
    end
    // ran off the end of the table
    scan_pos = feed_count;
    r.status = ST_END;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TimeW-1:0] any_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  function automatic stim_row_t row(opcode_t op, logic [TimeW-1:0] t,
                                    logic [PriceW-1:0] p, logic [QtyW-1:0] q,
                                    logic [SideW-1:0] s, bit typed = 1'b0,
                                    status_t st = ST_LOADED,
                                    logic [TimeW-1:0] d = '0,
                                    logic [IdxOutW-1:0] ix = '0);
    stim_row_t x;
    x.w               = '{opcode: op, time_us: t, price_cents: p, quantity: q, side: s};
    x.typed           = typed;
    x.want.status     = st;
    x.want.delay_us   = d;
    x.want.entry_index = ix;
    return x;
  endfunction

  // a word with every field drawn over its whole range
  function automatic in_word_t noise_word();
    in_word_t w;
    w.opcode      = 1'($urandom_range(0, 1));
    w.time_us     = any_time();
    w.price_cents = PriceW'($urandom);
    w.quantity    = QtyW'($urandom);
    w.side        = SideW'($urandom_range(0, 3));
    return w;
  endfunction

  // a feed event a little after the previous one, now and then far after
  function automatic in_word_t feed_event();
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) feed_time += TimeW'((64'($urandom_range(0, 3)) << 32) | 64'($urandom));
    else feed_time += TimeW'($urandom_range(0, 2000));
    w.opcode      = OP_APPEND;
    w.time_us     = feed_time;
    w.price_cents = base_price + PriceW'($urandom_range(0, 3));
    w.quantity    = ($urandom_range(0, 9) == 0) ? QtyW'($urandom)
                                                : QtyW'($urandom_range(1, 500));
    w.side        = SideW'($urandom_range(0, 3));
    return w;
  endfunction

  // an own trade aimed at an event a few entries past the cursor; a broken one
  // has its side, price or quantity spoilt
  function automatic in_word_t aimed_trade(bit broken);
    in_word_t    w;
    entry_t      e;
    int unsigned span;
    logic [63:0] lead;
    span = feed_count - scan_pos;
    e    = feed_tab[scan_pos + $urandom_range(0, (span > 8) ? 7 : span - 1)];
    lead = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3000));
    w.opcode      = OP_MATCH;
    w.time_us     = (e.time_us > TimeW'(lead)) ? e.time_us - TimeW'(lead) : '0;
    w.price_cents = e.price_cents;
    w.quantity    = QtyW'($urandom_range(0, e.qty));
    w.side        = e.side ^ SideW'($urandom_range(1, 3));
    if (broken) begin
      case ($urandom_range(0, 2))
        0: w.side = e.side;
        1: w.price_cents = e.price_cents ^ PriceW'(1 << $urandom_range(0, PriceW - 1));
        default: if (e.qty != QtyMax) w.quantity = e.qty + 1'b1;
      endcase
    end
    return w;
  endfunction

  task automatic flag(string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  // compares one result word with the oldest expectation
  task automatic check_word(out_word_t got);
    out_word_t want;
    if (outcome_q.size() == 0) begin
      flag($sformatf("result word %h with nothing pending", got));
      return;
    end
    want = outcome_q.pop_front();
    if (got.status !== want.status)
      flag($sformatf("status exp %0d got %0d", want.status, got.status));
    if (got.delay_us !== want.delay_us)
      flag($sformatf("delay_us exp %0d got %0d", want.delay_us, got.delay_us));
    if (got.entry_index !== want.entry_index)
      flag($sformatf("entry_index exp %0d got %0d", want.entry_index, got.entry_index));
  endtask

  // offers one word after an optional gap and waits until it is taken; valid is
  // left high so back-to-back words need no second assignment in a step
  task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
    int unsigned gap;
    out_word_t   predicted;
    gap = pick_gap(in_gaps);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= w;
    do @(posedge clk); while (!in_chan.ready);
    predicted = feed_outcome(w);
    outcome_q = {outcome_q, (typed ? want : predicted)};
  endtask

  // lets every outstanding result drain so the block sits idle
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(cfg_word_t v);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    window_us = v;
  endtask

  task automatic random_phase(int unsigned n_words);
    in_word_t    w;
    int unsigned r;
    for (int unsigned i = 0; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) w = noise_word();
      else if (r < 50 || scan_pos >= feed_count) w = feed_event();
      else w = aimed_trade(r >= 90);
      send_word(w);
    end
  endtask

  // result side: random stalls, checks each word taken
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) check_word(out_chan.data);
      if (hold != 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        hold = pick_gap(out_stalls);
        out_chan.ready <= (hold == 0);
      end
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    cfg.valid     = 1'b0;
    cfg.data      = '0;
    feed_time     = TimeW'($urandom_range(0, 1000000));
    base_price    = PriceW'($urandom_range(1, 1000000));

    // directed words, run under the reset window of 3 s
    directed_rows = '{
      // empty table: scan ends at once
      row(OP_MATCH,  0,       0,        0,      SideBuy,  1, ST_END),
      row(OP_APPEND, 1000,    12345,    10,     SideBuy,  1, ST_LOADED, 0, 0),
      row(OP_APPEND, 1500,    12345,    5,      SideSell, 1, ST_LOADED, 0, 1),
      row(OP_APPEND, 2000,    PriceMax, QtyMax, SideNone, 1, ST_LOADED, 0, 2),
      row(OP_APPEND, 3000,    0,        0,      SideOdd,  1, ST_LOADED, 0, 3),
      row(OP_APPEND, TimeMax, 777,      1,      SideSell, 1, ST_LOADED, 0, 4),
      // partial fill, then the rest of the same entry from the same cursor
      row(OP_MATCH,  900,     12345,    4,      SideSell, 1, ST_MATCHED, 100, 0),
      row(OP_MATCH,  900,     12345,    6,      SideSell, 1, ST_MATCHED, 100, 0),
      // misses then an event far past the window: give up, rewind
      row(OP_MATCH,  1000,    12345,    1,      SideSell, 1, ST_GAVE_UP),
      row(OP_MATCH,  1200,    12345,    5,      SideBuy),
      // no side against no side never matches
      row(OP_MATCH,  2000,    PriceMax, QtyMax, SideNone),
      row(OP_MATCH,  2000,    PriceMax, QtyMax, SideOdd),
      row(OP_MATCH,  2500,    0,        0,      SideBuy),
      row(OP_MATCH,  TimeMax, 777,      1,      SideBuy),
      // entry used up: scan runs off the end, then starts at the end
      row(OP_MATCH,  TimeMax, 777,      1,      SideBuy,  1, ST_END),
      row(OP_MATCH,  0,       PriceMax, QtyMax, SideOdd,  1, ST_END),
      row(OP_APPEND, 5000,    42,       100,    SideBuy,  1, ST_LOADED, 0, 5),
      row(OP_MATCH,  4000,    42,       100,    SideSell),
      row(OP_MATCH,  4000,    42,       1,      SideSell)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

    // random phases, window extremes among them; first phase runs flat out
    cfg_plan = '{32'd0, 32'hFFFF_FFFF, cfg_word_t'($urandom_range(0, 3000)),
                 MAX_DELAY_RESET, cfg_word_t'($urandom)};
    foreach (cfg_plan[k]) begin
      settle();
      write_window(cfg_plan[k]);
      in_gaps    = (k != 0) && (k != 2);
      out_stalls = (k != 0) && (k != 3);
      base_price = PriceW'($urandom_range(1, 1000000));
      random_phase(160);
    end

    settle();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
